// ===== hdl/lebe_pkg.sv =====
`default_nettype none
package lebe_pkg;

   localparam int unsigned PATTERN_DEPTH = 8;
   localparam int unsigned DIV_BITS      = 32;
   localparam int unsigned DVS_BITS      = 17;

   localparam logic [7:0]  LEVEL_FULL   = 8'hFF;
   localparam logic [7:0]  LEVEL_OFF    = 8'h00;
   localparam logic [15:0] PERIOD_RESET = 16'd1000;

   localparam logic [2:0] CSR_MODE         = 3'd0;
   localparam logic [2:0] CSR_PERIOD       = 3'd1;
   localparam logic [2:0] CSR_DIRECT_LEVEL = 3'd2;
   localparam logic [2:0] CSR_PAT_LENGTH   = 3'd3;
   localparam logic [2:0] CSR_PAT_LOW      = 3'd4;
   localparam logic [2:0] CSR_PAT_HIGH     = 3'd5;

   localparam logic [2:0] MODE_DIRECT   = 3'd0;
   localparam logic [2:0] MODE_BLINK    = 3'd1;
   localparam logic [2:0] MODE_PATTERN  = 3'd2;
   localparam logic [2:0] MODE_FADE_ON  = 3'd3;
   localparam logic [2:0] MODE_FADE_OFF = 3'd4;
   localparam logic [2:0] MODE_BREATHE  = 3'd5;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SETUP = 6'b000010,
      ST_MOD   = 6'b000100,
      ST_PREP  = 6'b001000,
      ST_RAMP  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/lebe_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle. done pulses when the last quotient bit is registered.
module lebe_div
   import lebe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIV_BITS-1:0]   dividend,
   input  wire logic [DVS_BITS-1:0]   divisor,
   output logic                       done,
   output logic [DIV_BITS-1:0]        quotient,
   output logic [DVS_BITS-1:0]        remainder
);

   localparam int unsigned CNT_BITS = $clog2(DIV_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_BITS - 1);

   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] dq_ff, dq_in;
   logic [DVS_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DVS_BITS+1:0] diff;

   always_comb begin
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      diff    = {1'b0, rem_ff, dq_ff[DIV_BITS-1]} - {2'b00, dvs_ff};
      if (start) begin
         rem_in  = '0;
         dq_in   = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DVS_BITS+1]) begin
            rem_in = diff[DVS_BITS-1:0];
         end else begin
            rem_in = {rem_ff[DVS_BITS-2:0], dq_ff[DIV_BITS-1]};
         end
         dq_in  = {dq_ff[DIV_BITS-2:0], ~diff[DVS_BITS+1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== hdl/led_effect_brightness_engine.sv =====
`default_nettype none
// LED effect brightness engine.
// req_ channel: one transaction per millisecond tick, tdata = now_ms.
// rsp_ channel: one transaction per tick, brightness and pattern step.
// csr_ port: write-only register file, index in csr_addr, data in csr_wdata;
//   any write to a mapped index restarts the effect on the next tick.
// req_tready returns high in the same cycle that the result enters the rsp
// register, so the next req transaction can be taken while it is still offered.
// One shared 32-step restoring divider serves the timed modes: blink and breathe
// use it for the elapsed-time remainder, fades and breathe for the ramp.
// req_tready is high only while no tick is in progress. A finished result
// sits in the rsp register while the next tick is taken; if rsp_tready is
// still low when that tick finishes, it waits in the engine.
// Reset returns the state, CSRs and effect state to their defaults and drops rsp_tvalid.
module led_effect_brightness_engine
   import lebe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [31:0] now_ms
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [7:0] brightness, [10:8] pattern_step
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [63:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [2:0]  mode_ff, mode_in;
   logic [15:0] period_ff, period_in;
   logic [7:0]  direct_ff, direct_in;
   logic [3:0]  pat_len_ff, pat_len_in;
   logic [63:0] pat_low_ff, pat_low_in;
   logic [63:0] pat_high_ff, pat_high_in;

   logic        started_ff, started_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [31:0] seg_ff, seg_in;
   logic [2:0]  step_ff, step_in;

   logic [31:0] now_ff, now_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic        first_ff, first_in;
   logic [15:0] ramp_x_ff, ramp_x_in;
   logic        inv_ff, inv_in;
   logic [7:0]  level_ff, level_in;
   logic [2:0]  step_out_ff, step_out_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_level_ff, rsp_level_in;
   logic [2:0]  rsp_step_ff, rsp_step_in;

   logic                div_start;
   logic [DIV_BITS-1:0] div_dividend;
   logic [DVS_BITS-1:0] div_divisor;
   logic                div_done;
   logic [DIV_BITS-1:0] div_quot;
   logic [DVS_BITS-1:0] div_rem;

   logic [15:0] period_used;
   logic [3:0]  len_used;
   logic [2:0]  step_cur;
   logic [3:0]  step_inc;
   logic [63:0] dur_word;
   logic [15:0] dur;
   logic [16:0] pos;
   logic [16:0] pos_minus;
   logic [23:0] ramp_scaled;
   logic        cfg_clear;

   lebe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign period_used = (period_ff == 16'd0) ? 16'd1 : period_ff;

   always_comb begin
      if (pat_len_ff == 4'd0) begin
         len_used = 4'd1;
      end else if (pat_len_ff > 4'(PATTERN_DEPTH)) begin
         len_used = 4'(PATTERN_DEPTH);
      end else begin
         len_used = pat_len_ff;
      end
      step_cur    = ({1'b0, step_ff} >= len_used) ? 3'd0 : step_ff;
      step_inc    = {1'b0, step_cur} + 4'd1;
      dur_word    = step_cur[2] ? pat_high_ff : pat_low_ff;
      dur         = dur_word[{step_cur[1:0], 4'b0000} +: 16];
      pos         = {div_rem[15:0], 1'b0};
      pos_minus   = pos - {1'b0, period_used};
      ramp_scaled = {ramp_x_ff, 8'h00} - {8'h00, ramp_x_ff};
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      period_in    = period_ff;
      direct_in    = direct_ff;
      pat_len_in   = pat_len_ff;
      pat_low_in   = pat_low_ff;
      pat_high_in  = pat_high_ff;
      started_in   = started_ff;
      stamp_in     = stamp_ff;
      seg_in       = seg_ff;
      step_in      = step_ff;
      now_in       = now_ff;
      elapsed_in   = elapsed_ff;
      first_in     = first_ff;
      ramp_x_in    = ramp_x_ff;
      inv_in       = inv_ff;
      level_in     = level_ff;
      step_out_in  = step_out_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      rsp_step_in  = rsp_step_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      cfg_clear    = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_MODE: begin
               mode_in   = csr_wdata[2:0];
               cfg_clear = 1'b1;
            end
            CSR_PERIOD: begin
               period_in = csr_wdata[15:0];
               cfg_clear = 1'b1;
            end
            CSR_DIRECT_LEVEL: begin
               direct_in = csr_wdata[7:0];
               cfg_clear = 1'b1;
            end
            CSR_PAT_LENGTH: begin
               pat_len_in = csr_wdata[3:0];
               cfg_clear  = 1'b1;
            end
            CSR_PAT_LOW: begin
               pat_low_in = csr_wdata;
               cfg_clear  = 1'b1;
            end
            CSR_PAT_HIGH: begin
               pat_high_in = csr_wdata;
               cfg_clear   = 1'b1;
            end
            default: ;
         endcase
         if (cfg_clear) begin
            started_in = 1'b0;
            step_in    = 3'd0;
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               now_in = req_tdata;
               if (mode_ff >= MODE_BLINK && mode_ff <= MODE_BREATHE && !started_ff) begin
                  started_in = 1'b1;
                  stamp_in   = req_tdata;
                  elapsed_in = 32'd0;
                  first_in   = 1'b1;
               end else begin
                  elapsed_in = req_tdata - stamp_ff;
                  first_in   = 1'b0;
               end
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            step_out_in = 3'd0;
            unique case (mode_ff)
               MODE_BLINK, MODE_BREATHE: begin
                  div_start    = 1'b1;
                  div_dividend = elapsed_ff;
                  div_divisor  = (mode_ff == MODE_BLINK) ? {period_used, 1'b0}
                                                         : {1'b0, period_used};
                  state_in     = ST_MOD;
               end
               MODE_FADE_ON, MODE_FADE_OFF: begin
                  if (elapsed_ff >= {16'h0000, period_used}) begin
                     level_in = (mode_ff == MODE_FADE_ON) ? LEVEL_FULL : LEVEL_OFF;
                     state_in = ST_DONE;
                  end else begin
                     ramp_x_in = elapsed_ff[15:0];
                     inv_in    = (mode_ff == MODE_FADE_OFF);
                     state_in  = ST_PREP;
                  end
               end
               MODE_PATTERN: begin
                  step_in = step_cur;
                  if (first_ff) begin
                     seg_in = now_ff;
                  end else if ((now_ff - seg_ff) >= {16'h0000, dur}) begin
                     seg_in  = now_ff;
                     step_in = (step_inc >= len_used) ? 3'd0 : step_inc[2:0];
                  end
                  level_in    = step_in[0] ? LEVEL_OFF : LEVEL_FULL;
                  step_out_in = step_in;
                  state_in    = ST_DONE;
               end
               default: begin
                  level_in = direct_ff;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_MOD: begin
            if (div_done) begin
               if (mode_ff == MODE_BLINK) begin
                  level_in = (div_rem < {1'b0, period_used}) ? LEVEL_FULL : LEVEL_OFF;
                  state_in = ST_DONE;
               end else begin
                  if (pos < {1'b0, period_used}) begin
                     ramp_x_in = pos[15:0];
                     inv_in    = 1'b0;
                  end else begin
                     ramp_x_in = pos_minus[15:0];
                     inv_in    = 1'b1;
                  end
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            div_start    = 1'b1;
            div_dividend = {8'h00, ramp_scaled};
            div_divisor  = {1'b0, period_used};
            state_in     = ST_RAMP;
         end
         ST_RAMP: begin
            if (div_done) begin
               level_in = inv_ff ? (LEVEL_FULL - div_quot[7:0]) : div_quot[7:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               rsp_step_in  = step_out_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_DIRECT;
         period_ff    <= PERIOD_RESET;
         direct_ff    <= 8'h00;
         pat_len_ff   <= 4'd1;
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         started_ff   <= 1'b0;
         stamp_ff     <= '0;
         seg_ff       <= '0;
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         period_ff    <= period_in;
         direct_ff    <= direct_in;
         pat_len_ff   <= pat_len_in;
         pat_low_ff   <= pat_low_in;
         pat_high_ff  <= pat_high_in;
         started_ff   <= started_in;
         stamp_ff     <= stamp_in;
         seg_ff       <= seg_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff       <= now_in;
      elapsed_ff   <= elapsed_in;
      first_ff     <= first_in;
      ramp_x_ff    <= ramp_x_in;
      inv_ff       <= inv_in;
      level_ff     <= level_in;
      step_out_ff  <= step_out_in;
      rsp_level_ff <= rsp_level_in;
      rsp_step_ff  <= rsp_step_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_step_ff, rsp_level_ff};

endmodule
`default_nettype wire

// ===== hdl/lebe_checker.sv =====
`default_nettype none
module lebe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // one tick at a time: busy right after a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after a transaction");

   // odd pattern step drives the LED off
   a_odd_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[7:0] == 8'h00)
      else $error("odd pattern step with nonzero brightness");

   // nonzero even pattern step drives the LED full on
   a_even_on: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] && (rsp_tdata[10:9] != 2'b00)
      |-> rsp_tdata[7:0] == 8'hFF)
      else $error("even pattern step without full brightness");

endmodule

bind led_effect_brightness_engine lebe_checker u_lebe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== tb/sv/led_effect_brightness_engine_tb.sv =====
`timescale 1ns / 1ps
module led_effect_brightness_engine_tb;
   import lebe_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 5000;
   localparam int unsigned TAIL_CYCLES  = 100;
   localparam int unsigned RANDOM_TICKS = 675;
   localparam int unsigned PRINT_CAP    = 100;

   typedef enum bit {ROW_TICK, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0]   addr;
      logic [63:0]  value;
      bit           pinned;
      logic [7:0]   level;
      logic [2:0]   step;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] level;
      logic [2:0] step;
   } led_out_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en  = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [63:0] csr_wdata  = '0;

   logic [2:0]  m_mode;
   logic [15:0] m_period;
   logic [7:0]  m_direct;
   logic [3:0]  m_length;
   logic [63:0] m_pat_low;
   logic [63:0] m_pat_high;
   bit          m_started;
   logic [31:0] m_start_stamp;
   logic [31:0] m_segment_start;
   logic [2:0]  m_step;
   logic [7:0]  m_held;

   led_out_type  pending_levels[$];
   stim_row_type directed_rows[$];
   bit           pin_on       = 1'b0;
   led_out_type  pin_out      = '0;
   int           snd_idle_pct = 0;
   int           rcv_idle_pct = 0;
   int           error_count  = 0;
   int unsigned  quiet_cycles = 0;

   led_effect_brightness_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < PRINT_CAP)
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic logic [7:0] ramp_level(input logic [31:0] t, input logic [31:0] p);
      logic [63:0] prod;
      if (t >= p) return LEVEL_FULL;
      prod = 64'(t) * 64'd255;
      return 8'(prod / 64'(p));
   endfunction

   function automatic logic [15:0] pattern_duration(input logic [2:0] k);
      logic [63:0] word;
      word = k[2] ? m_pat_high : m_pat_low;
      return word[k[1:0]*16 +: 16];
   endfunction

   task automatic apply_csr(input logic [2:0] addr, input logic [63:0] data);
      if (addr <= CSR_PAT_HIGH) begin
         case (addr)
            CSR_MODE:         m_mode     = data[2:0];
            CSR_PERIOD:       m_period   = data[15:0];
            CSR_DIRECT_LEVEL: m_direct   = data[7:0];
            CSR_PAT_LENGTH:   m_length   = data[3:0];
            CSR_PAT_LOW:      m_pat_low  = data;
            default:          m_pat_high = data;
         endcase
         m_started = 1'b0;
         m_step    = 3'd0;
      end
   endtask

   task automatic predict_brightness(input logic [31:0] now_ms, output led_out_type res);
      logic [31:0] p;
      logic [31:0] elapsed;
      logic [31:0] pos;
      logic [31:0] n;
      logic [31:0] seg_age;
      logic [7:0]  lvl;
      logic [2:0]  stp;
      bit          first;
      p     = (m_period == 16'd0) ? 32'd1 : 32'(m_period);
      first = !m_started;
      stp   = 3'd0;
      if (m_mode >= MODE_BLINK && m_mode <= MODE_BREATHE && first) begin
         m_started     = 1'b1;
         m_start_stamp = now_ms;
      end
      elapsed = now_ms - m_start_stamp;
      case (m_mode)
         MODE_BLINK: begin
            pos = elapsed % (32'd2 * p);
            lvl = (pos < p) ? LEVEL_FULL : LEVEL_OFF;
         end
         MODE_PATTERN: begin
            if (m_length == 4'd0)
               n = 32'd1;
            else if (32'(m_length) > PATTERN_DEPTH)
               n = PATTERN_DEPTH;
            else
               n = 32'(m_length);
            if (32'(m_step) >= n) m_step = 3'd0;
            seg_age = now_ms - m_segment_start;
            if (first) begin
               m_segment_start = now_ms;
            end else if (seg_age >= 32'(pattern_duration(m_step))) begin
               m_segment_start = now_ms;
               m_step = (32'(m_step) + 32'd1 >= n) ? 3'd0 : m_step + 3'd1;
            end
            lvl = m_step[0] ? LEVEL_OFF : LEVEL_FULL;
            stp = m_step;
         end
         MODE_FADE_ON:  lvl = ramp_level(elapsed, p);
         MODE_FADE_OFF: lvl = LEVEL_FULL - ramp_level(elapsed, p);
         MODE_BREATHE: begin
            pos = (elapsed % p) * 32'd2;
            lvl = (pos < p) ? ramp_level(pos, p) : LEVEL_FULL - ramp_level(pos - p, p);
         end
         default: lvl = m_direct;
      endcase
      m_held    = lvl;
      res.level = lvl;
      res.step  = stp;
   endtask

   always @(posedge clock) begin : monitor
      led_out_type got;
      led_out_type want;
      led_out_type pred;
      if (reset) begin
         m_mode          = MODE_DIRECT;
         m_period        = PERIOD_RESET;
         m_direct        = LEVEL_OFF;
         m_length        = 4'd1;
         m_pat_low       = '0;
         m_pat_high      = '0;
         m_started       = 1'b0;
         m_start_stamp   = '0;
         m_segment_start = '0;
         m_step          = 3'd0;
         m_held          = LEVEL_OFF;
         pending_levels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.level = rsp_tdata[7:0];
            got.step  = rsp_tdata[10:8];
            if (pending_levels.size() == 0) begin
               report_mismatch("unexpected transaction", 32'(rsp_tdata), 32'd0);
            end else begin
               want = pending_levels.pop_front();
               if (got.level !== want.level)
                  report_mismatch("brightness", 32'(got.level), 32'(want.level));
               if (got.step !== want.step)
                  report_mismatch("pattern_step", 32'(got.step), 32'(want.step));
            end
         end
         if (csr_wr_en) apply_csr(csr_addr, csr_wdata);
         if (req_tvalid && req_tready) begin
            predict_brightness(req_tdata, pred);
            pending_levels.push_back(pin_on ? pin_out : pred);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   function automatic void add_cfg(input logic [2:0] addr, input logic [63:0] value);
      stim_row_type row;
      row.kind   = ROW_CFG;
      row.addr   = addr;
      row.value  = value;
      row.pinned = 1'b0;
      row.level  = LEVEL_OFF;
      row.step   = 3'd0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_tick(input logic [31:0] now_ms, input bit pinned,
                                    input logic [7:0] level, input logic [2:0] step);
      stim_row_type row;
      row.kind   = ROW_TICK;
      row.addr   = CSR_MODE;
      row.value  = 64'(now_ms);
      row.pinned = pinned;
      row.level  = level;
      row.step   = step;
      directed_rows.push_back(row);
   endfunction

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [63:0] data);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_tick(input logic [31:0] now_ms, input bit pinned,
                            input led_out_type pinned_out);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= now_ms;
      pin_on     <= pinned;
      pin_out    <= pinned_out;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic randomize_settings();
      logic [63:0] v;
      int unsigned pick;
      for (int r = 0; r <= int'(CSR_PAT_HIGH); r++) begin
         if (3'(r) != CSR_MODE && $urandom_range(1) == 0) continue;
         v = {$urandom, $urandom};
         case (3'(r))
            CSR_MODE: begin
               if ($urandom_range(9) < 7) v[2:0] = 3'($urandom_range(1, 5));
            end
            CSR_PERIOD: begin
               pick = $urandom_range(9);
               case (pick)
                  0:       v[15:0] = 16'd0;
                  1:       v[15:0] = 16'd1;
                  2:       v[15:0] = 16'hFFFF;
                  3:       v[15:0] = 16'($urandom);
                  default: v[15:0] = 16'($urandom_range(2, 40));
               endcase
            end
            CSR_PAT_LOW, CSR_PAT_HIGH: begin
               for (int k = 0; k < 4; k++)
                  if ($urandom_range(3) != 0) v[k*16 +: 16] = 16'($urandom_range(6));
            end
            default: ;
         endcase
         write_csr(3'(r), v);
      end
      // unmapped index: no effect on the engine
      if ($urandom_range(9) == 0)
         write_csr(CSR_PAT_HIGH + 3'($urandom_range(1, 2)), {$urandom, $urandom});
   endtask

   initial begin
      logic [31:0] stamp;
      int unsigned pick;
      int unsigned burst;
      int          sent;

      add_tick(32'd0, 1'b1, LEVEL_OFF, 3'd0);
      add_cfg(CSR_DIRECT_LEVEL, 64'hFF);
      add_tick(32'hFFFF_FFFF, 1'b1, LEVEL_FULL, 3'd0);
      add_cfg(CSR_MODE, 64'd7);
      add_tick(32'd5, 1'b1, LEVEL_FULL, 3'd0);
      add_cfg(CSR_MODE, 64'd6);
      add_tick(32'd6, 1'b1, LEVEL_FULL, 3'd0);
      add_cfg(CSR_MODE, 64'(MODE_BLINK));
      add_cfg(CSR_PERIOD, 64'd0);
      add_tick(32'd100, 1'b1, LEVEL_FULL, 3'd0);
      add_tick(32'd101, 1'b1, LEVEL_OFF, 3'd0);
      add_cfg(CSR_PERIOD, 64'hFFFF);
      add_tick(32'hFFFF_FFFF, 1'b1, LEVEL_FULL, 3'd0);
      add_tick(32'h0000_FFFE, 1'b1, LEVEL_OFF, 3'd0);
      add_cfg(CSR_MODE, 64'(MODE_FADE_ON));
      add_cfg(CSR_PERIOD, 64'd10);
      add_tick(32'd50, 1'b1, LEVEL_OFF, 3'd0);
      add_tick(32'd55, 1'b0, LEVEL_OFF, 3'd0);
      add_tick(32'd60, 1'b1, LEVEL_FULL, 3'd0);
      add_tick(32'd1000, 1'b1, LEVEL_FULL, 3'd0);
      add_cfg(CSR_MODE, 64'(MODE_FADE_OFF));
      add_tick(32'd7, 1'b1, LEVEL_FULL, 3'd0);
      add_tick(32'd12, 1'b0, LEVEL_OFF, 3'd0);
      add_tick(32'd99, 1'b1, LEVEL_OFF, 3'd0);
      add_cfg(CSR_MODE, 64'(MODE_BREATHE));
      add_cfg(CSR_PERIOD, 64'd4);
      add_tick(32'd0, 1'b1, LEVEL_OFF, 3'd0);
      add_tick(32'd1, 1'b0, LEVEL_OFF, 3'd0);
      add_tick(32'd2, 1'b0, LEVEL_OFF, 3'd0);
      add_cfg(CSR_MODE, 64'(MODE_PATTERN));
      add_cfg(CSR_PAT_LENGTH, 64'd0);
      add_tick(32'd10, 1'b1, LEVEL_FULL, 3'd0);
      add_cfg(CSR_PAT_LENGTH, 64'd15);
      add_cfg(CSR_PAT_LOW, 64'h0003_0000_0001_0002);
      add_cfg(CSR_PAT_HIGH, 64'hFFFF_0000_0001_0000);
      add_tick(32'd20, 1'b1, LEVEL_FULL, 3'd0);
      add_tick(32'd21, 1'b0, LEVEL_OFF, 3'd0);
      add_tick(32'd22, 1'b0, LEVEL_OFF, 3'd0);
      add_tick(32'd23, 1'b0, LEVEL_OFF, 3'd0);
      add_tick(32'd24, 1'b0, LEVEL_OFF, 3'd0);
      add_tick(32'd25, 1'b0, LEVEL_OFF, 3'd0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            drain_results();
            write_csr(directed_rows[i].addr, directed_rows[i].value);
         end else begin
            send_tick(directed_rows[i].value[31:0], directed_rows[i].pinned,
                      {directed_rows[i].level, directed_rows[i].step});
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         drain_results();
         case (ph)
            0:       begin snd_idle_pct = 22; rcv_idle_pct = 82; end
            1:       begin snd_idle_pct = 82; rcv_idle_pct = 22; end
            default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
         endcase
         sent = 0;
         while (sent < int'(RANDOM_TICKS / 3)) begin
            drain_results();
            randomize_settings();
            if ($urandom_range(4) == 0)
               stamp = 32'hFFFF_FFFF - 32'($urandom_range(60));
            else
               stamp = $urandom;
            burst = $urandom_range(8, 40);
            repeat (burst) begin
               pick = $urandom_range(99);
               if (pick < 80)
                  stamp = stamp + 32'd1;
               else if (pick >= 88 && pick < 95)
                  stamp = stamp + 32'($urandom_range(2, 300));
               else if (pick >= 95)
                  stamp = $urandom;
               send_tick(stamp, 1'b0, '0);
               sent++;
            end
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
